>>> src/assert_macros.svh
// assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);

`endif

>>> src/mrd_pkg.sv
package mrd_pkg;

  localparam int unsigned NUM_W       = 32;
  localparam int unsigned RADIX_W     = 9;
  localparam int unsigned DIGIT_W     = 8;
  localparam int unsigned POS_W       = 2;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned RADIX_REGS  = 4;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 9;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned BIT_CNT_W   = $clog2(NUM_W);

  localparam int unsigned MAX_DIGITS_DEF = 4;
  localparam int unsigned DIGIT_BITS_DEF = 8;

  localparam logic [CNT_W-1:0]   DC_RESET    = 3'd4;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 9'd2;

  // register indexes of the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIX_0     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIX_1     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIX_2     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RADIX_3     = 3'd4;

  typedef struct packed {
    logic             load;
    logic             step;
    logic             store;
    logic             emit;
    logic             last;
    logic             big;
    logic [POS_W-1:0] idx;
  } mrd_cmd_t;

  typedef struct packed {
    logic out_free;
    logic quot_zero;
  } mrd_sts_t;

endpackage

>>> src/mrd_regs.sv
module mrd_regs
  import mrd_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF,
  parameter int unsigned DIGIT_BITS = DIGIT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]                cfg_index_i,
  input  logic [CFG_DATA_W-1:0]               cfg_data_i,
  output logic [CNT_W-1:0]                    count_o,
  output logic [RADIX_REGS-1:0][RADIX_W-1:0]  radix_o
);

  localparam int unsigned Cap    = (MAX_DIGITS < RADIX_REGS) ? MAX_DIGITS : RADIX_REGS;
  localparam int unsigned TopVal = 1 << DIGIT_BITS;

  logic [CNT_W-1:0]                   dc_q;
  logic [RADIX_REGS-1:0][RADIX_W-1:0] radix_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_q    <= DC_RESET;
      radix_q <= {RADIX_REGS{RADIX_RESET}};
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_DIGIT_COUNT: dc_q       <= cfg_data_i[CNT_W-1:0];
        REG_RADIX_0:     radix_q[0] <= cfg_data_i[RADIX_W-1:0];
        REG_RADIX_1:     radix_q[1] <= cfg_data_i[RADIX_W-1:0];
        REG_RADIX_2:     radix_q[2] <= cfg_data_i[RADIX_W-1:0];
        REG_RADIX_3:     radix_q[3] <= cfg_data_i[RADIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (dc_q == '0) begin
      count_o = CNT_W'(1);
    end else if (dc_q > CNT_W'(Cap)) begin
      count_o = CNT_W'(Cap);
    end else begin
      count_o = dc_q;
    end
  end

  // radix zero acts as one, anything above 2^DIGIT_BITS saturates
  for (genvar i = 0; i < RADIX_REGS; i++) begin : g_radix
    always_comb begin
      if (radix_q[i] == '0) begin
        radix_o[i] = RADIX_W'(1);
      end else if (int'(radix_q[i]) > TopVal) begin
        radix_o[i] = RADIX_W'(TopVal);
      end else begin
        radix_o[i] = radix_q[i];
      end
    end
  end

endmodule

>>> src/mrd_dpath.sv
module mrd_dpath
  import mrd_pkg::*;
#(
  parameter int unsigned DIGIT_BITS = DIGIT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [NUM_W-1:0]                    number_i,
  input  logic [RADIX_REGS-1:0][RADIX_W-1:0]  radix_i,
  input  mrd_cmd_t                            cmd_i,
  output mrd_sts_t                            sts_o,
  input  logic                                m_tready_i,
  output logic                                m_tvalid_o,
  output logic [DIGIT_W-1:0]                  digit_o,
  output logic [POS_W-1:0]                    position_o,
  output logic                                last_o,
  output logic                                too_large_o
);

  localparam int unsigned DigMask = (1 << DIGIT_BITS) - 1;

  logic [NUM_W-1:0]   num_q;
  logic [RADIX_W-1:0] rem_q;
  logic [RADIX_W-1:0] digit_q [RADIX_REGS];
  logic [RADIX_W:0]   trial;
  logic [RADIX_W:0]   divisor;
  logic [RADIX_W:0]   diff;
  logic               ge;

  logic               out_valid_q;
  logic [DIGIT_W-1:0] out_digit_q;
  logic [POS_W-1:0]   out_pos_q;
  logic               out_last_q;
  logic               out_big_q;

  // one restoring step a cycle, quotient bits shift into the number register
  assign divisor = {1'b0, radix_i[cmd_i.idx]};
  assign trial   = {rem_q, num_q[NUM_W-1]};
  assign diff    = trial - divisor;
  assign ge      = (trial >= divisor);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      num_q <= number_i;
      rem_q <= '0;
    end else if (cmd_i.step) begin
      num_q <= {num_q[NUM_W-2:0], ge};
      rem_q <= ge ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
    end else if (cmd_i.store) begin
      digit_q[cmd_i.idx] <= rem_q;
      rem_q              <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_digit_q <= cmd_i.big ? '0
                   : (digit_q[cmd_i.idx][DIGIT_W-1:0] & DIGIT_W'(DigMask));
      out_pos_q   <= cmd_i.idx;
      out_last_q  <= cmd_i.last;
      out_big_q   <= cmd_i.big;
    end
  end

  assign sts_o.out_free  = !out_valid_q || m_tready_i;
  assign sts_o.quot_zero = (num_q == '0);

  assign m_tvalid_o  = out_valid_q;
  assign digit_o     = out_digit_q;
  assign position_o  = out_pos_q;
  assign last_o      = out_last_q;
  assign too_large_o = out_big_q;

endmodule

>>> src/mrd_ctrl.sv
module mrd_ctrl
  import mrd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  logic [CNT_W-1:0] count_i,
  input  mrd_sts_t         sts_i,
  output mrd_cmd_t         cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIV   = 4'b0010,
    ST_STORE = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [BIT_CNT_W-1:0] bit_cnt_q, bit_cnt_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic [POS_W-1:0]     last_pos_q, last_pos_d;
  logic [CNT_W-1:0]     cnt_m1;
  logic                 big;

  assign cnt_m1 = count_i - CNT_W'(1);
  assign big    = !sts_i.quot_zero;

  always_comb begin
    state_d    = state_q;
    bit_cnt_d  = bit_cnt_q;
    pos_d      = pos_q;
    last_pos_d = last_pos_q;
    cmd_o      = '0;
    cmd_o.idx  = pos_q;
    s_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          bit_cnt_d  = '0;
          pos_d      = cnt_m1[POS_W-1:0];
          last_pos_d = cnt_m1[POS_W-1:0];
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        bit_cnt_d  = bit_cnt_q + BIT_CNT_W'(1);
        if (bit_cnt_q == BIT_CNT_W'(NUM_W - 1)) begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd_o.store = 1'b1;
        bit_cnt_d   = '0;
        if (pos_q == '0) begin
          state_d = ST_EMIT;
        end else begin
          pos_d   = pos_q - POS_W'(1);
          state_d = ST_DIV;
        end
      end
      ST_EMIT: begin
        // a nonzero final quotient means the number did not fit
        cmd_o.big  = big;
        cmd_o.last = big || (pos_q == last_pos_q);
        cmd_o.emit = sts_i.out_free;
        if (sts_i.out_free) begin
          if (cmd_o.last) begin
            state_d = ST_IDLE;
          end else begin
            pos_d = pos_q + POS_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      bit_cnt_q  <= '0;
      pos_q      <= '0;
      last_pos_q <= '0;
    end else begin
      state_q    <= state_d;
      bit_cnt_q  <= bit_cnt_d;
      pos_q      <= pos_d;
      last_pos_q <= last_pos_d;
    end
  end

endmodule

>>> src/mixed_radix_digits.sv
// mixed-radix digit splitter
// input stream: one 32-bit unsigned number per item on s_axis_tdata.
// output stream: one item per active digit, most significant position first;
// tdata carries digit and position, tlast marks the final digit, tuser flags
// a number that is not below the product of the active radices (then a
// single item with zero digit, position 0 and tlast set is sent).
// configuration: cfg channel writes digit count (index 0) and radices 0..3
// (indices 1..4); other indices are ignored. cfg_ready_o is always high.
// write only while no item is in flight.
// operation: a single shared restoring divider works through the active
// positions from the highest down to position 0: for each it divides the number
// by that position's radix bit by bit, then stores the remainder as the digit;
// only then are the digits handed out, and no new number is taken during
// division or hand-out.
// a stalled receiver holds the output register and halts digit hand-out; the
// next number is accepted once the final digit sits in the output register.
// reset: digit count 4, every radix 2, no output pending, input ready.
module mixed_radix_digits
  import mrd_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF,
  parameter int unsigned DIGIT_BITS = DIGIT_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [NUM_W-1:0]       s_axis_tdata,   // number[31:0]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // digit[7:0], position[9:8], zero[15:10]
  output logic                   m_axis_tlast,
  output logic                   m_axis_tuser,   // too_large[0]
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  logic [CNT_W-1:0]                   count;
  logic [RADIX_REGS-1:0][RADIX_W-1:0] radix;
  mrd_cmd_t                           cmd;
  mrd_sts_t                           sts;
  logic [DIGIT_W-1:0]                 digit;
  logic [POS_W-1:0]                   position;

  mrd_regs #(
    .MAX_DIGITS (MAX_DIGITS),
    .DIGIT_BITS (DIGIT_BITS)
  ) u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .count_o     (count),
    .radix_o     (radix)
  );

  mrd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .count_i    (count),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mrd_dpath #(
    .DIGIT_BITS (DIGIT_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .number_i    (s_axis_tdata),
    .radix_i     (radix),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_tready_i  (m_axis_tready),
    .m_tvalid_o  (m_axis_tvalid),
    .digit_o     (digit),
    .position_o  (position),
    .last_o      (m_axis_tlast),
    .too_large_o (m_axis_tuser)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - DIGIT_W - POS_W)'(0), position, digit};

endmodule

>>> src/mrd_checker.sv
`include "assert_macros.svh"

module mrd_checker
  import mrd_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast,
  input logic                   m_axis_tuser
);

  logic in_acc;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  // an overflow item stands alone with all data bits clear
  `ASSERT_PROP(a_big_alone, clk_i, rst_ni,
               (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == '0),
               "too-large item must be last with zero data")

  // the divider is busy once a number is taken, so input ready drops
  `ASSERT_PROP(a_busy_after_accept, clk_i, rst_ni,
               in_acc |=> !s_axis_tready,
               "input ready again right after an accepted number")

  `ASSERT_PROP(a_out_hold, clk_i, rst_ni,
               (m_axis_tvalid && !m_axis_tready) |=>
               (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
                && $stable(m_axis_tuser)),
               "stalled output item changed")

  `ASSERT_NEVER(a_pad_zero, clk_i, rst_ni,
                m_axis_tvalid && m_axis_tdata[OUT_TDATA_W-1:DIGIT_W+POS_W] != '0,
                "padding bits of output data not zero")

endmodule

bind mixed_radix_digits mrd_checker u_mrd_checker (.*);

>>> sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mrd_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 330;
  localparam int unsigned PLAN_ROWS     = 50;
  localparam int unsigned HOLD_PHASE    = 3;
  localparam int unsigned HOLD_CYCLES   = 500;
  localparam int unsigned DRAIN_CYCLES  = 160;
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned ACTIVE_CAP    = (MAX_DIGITS_DEF < RADIX_REGS) ? MAX_DIGITS_DEF
                                                                        : RADIX_REGS;
  localparam logic [RADIX_W-1:0] RADIX_TOP = 9'd256;

  // indexes that the block has no register for
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [POS_W-1:0]   position;
    logic               last;
    logic               too_large;
  } digit_item_t;

  typedef enum logic {ROW_WRITE, ROW_NUMBER} row_kind_e;

  typedef struct packed {
    row_kind_e                   kind;
    logic [CFG_IDX_W-1:0]        index;
    logic [NUM_W-1:0]            value;
    logic                        typed;
    logic                        oversize;
    logic [CNT_W-1:0]            n_digits;
    logic [0:3][DIGIT_W-1:0]     digits;   // position 0 first
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [NUM_W-1:0]       s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // digit[7:0], position[9:8], zero[15:10]
  logic                   m_axis_tlast;
  logic                   m_axis_tuser;   // too_large[0]
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  // shadow of the configuration registers
  logic [CNT_W-1:0]   count_q = DC_RESET;
  logic [RADIX_W-1:0] radix_q [RADIX_REGS] = '{RADIX_RESET, RADIX_RESET, RADIX_RESET,
                                               RADIX_RESET};

  digit_item_t digits_due [$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit          steady = 1'b0;
  bit          hold_out_req = 1'b0;
  bit          fed_since_settle = 1'b0;
  plan_row_t   plan [PLAN_ROWS];

  mixed_radix_digits dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic plan_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
    plan_row_t r;
    r = '0;
    r.kind  = ROW_WRITE;
    r.index = idx;
    r.value = NUM_W'(data);
    return r;
  endfunction

  function automatic plan_row_t number_row(input logic [NUM_W-1:0] num);
    plan_row_t r;
    r = '0;
    r.kind  = ROW_NUMBER;
    r.value = num;
    return r;
  endfunction

  function automatic plan_row_t digits_row(input logic [NUM_W-1:0] num,
                                           input logic [CNT_W-1:0] n,
                                           input logic [0:3][DIGIT_W-1:0] d);
    plan_row_t r;
    r = number_row(num);
    r.typed    = 1'b1;
    r.n_digits = n;
    r.digits   = d;
    return r;
  endfunction

  function automatic plan_row_t oversize_row(input logic [NUM_W-1:0] num);
    plan_row_t r;
    r = number_row(num);
    r.typed    = 1'b1;
    r.oversize = 1'b1;
    return r;
  endfunction

  function automatic logic [RADIX_W-1:0] live_radix(input logic [RADIX_W-1:0] r);
    if (r == '0) begin
      return 9'd1;
    end
    return (r > RADIX_TOP) ? RADIX_TOP : r;
  endfunction

  function automatic int unsigned live_count();
    int unsigned n;
    n = count_q;
    if (n == 0) begin
      n = 1;
    end
    return (n > ACTIVE_CAP) ? ACTIVE_CAP : n;
  endfunction

  function automatic logic [63:0] radix_product();
    logic [63:0] p;
    p = 64'd1;
    for (int k = 0; k < live_count(); k++) begin
      p = p * live_radix(radix_q[k]);
    end
    return p;
  endfunction

  // appends one expected digit item at the tail
  task automatic due_add(input digit_item_t it);
    digits_due.insert(digits_due.size(), it);
  endtask

  task automatic predict_digits(input logic [NUM_W-1:0] num);
    logic [63:0]        quotient;
    logic [63:0]        r;
    logic [DIGIT_W-1:0] dig [RADIX_REGS];
    int                 used;
    used = live_count();
    if ({32'd0, num} >= radix_product()) begin
      due_add('{digit: '0, position: '0, last: 1'b1, too_large: 1'b1});
    end else begin
      quotient = {32'd0, num};
      // least significant position first
      for (int k = used - 1; k >= 0; k--) begin
        r = 64'(live_radix(radix_q[k]));
        dig[k] = DIGIT_W'(quotient % r);
        quotient = quotient / r;
      end
      for (int k = 0; k < used; k++) begin
        due_add('{digit: dig[k], position: POS_W'(k),
                  last: (k == used - 1), too_large: 1'b0});
      end
    end
  endtask

  task automatic queue_table_digits(input plan_row_t row);
    if (row.oversize) begin
      due_add('{digit: '0, position: '0, last: 1'b1, too_large: 1'b1});
    end else begin
      for (int k = 0; k < row.n_digits; k++) begin
        due_add('{digit: row.digits[k], position: POS_W'(k),
                  last: (k == row.n_digits - 1), too_large: 1'b0});
      end
    end
  endtask

  // lowers the input and waits until every digit has come out
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (digits_due.size() != 0) begin
      @(posedge clk);
    end
    fed_since_settle = 1'b0;
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    if (fed_since_settle) begin
      settle();
    end
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(posedge clk);
    end while (!cfg_ready_o);
    if (idx == REG_DIGIT_COUNT) begin
      count_q = data[CNT_W-1:0];
    end else if (idx >= REG_RADIX_0 && idx <= REG_RADIX_3) begin
      radix_q[idx - REG_RADIX_0] = data[RADIX_W-1:0];
    end
  endtask

  task automatic feed_number(input logic [NUM_W-1:0] num);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 19);
    cfg_valid_i <= 1'b0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= num;
    do begin
      @(posedge clk);
    end while (!s_axis_tready);
    fed_since_settle = 1'b1;
  endtask

  function automatic logic [RADIX_W-1:0] pick_radix();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 9'd1;
      2:       return RADIX_TOP;
      3:       return RADIX_W'($urandom_range(257, 511));
      default: return RADIX_W'($urandom_range(2, 255));
    endcase
  endfunction

  function automatic logic [NUM_W-1:0] pick_number();
    logic [63:0] p;
    p = radix_product();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return NUM_W'(p - 64'd1);
      2:       return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : NUM_W'(p);
      3:       return $urandom;
      default: return NUM_W'({32'd0, $urandom} % p);
    endcase
  endfunction

  task automatic program_phase();
    logic [CFG_DATA_W-1:0] count_data;
    count_data = {(CFG_DATA_W - CNT_W)'($urandom_range(0, 63)),
                  CNT_W'($urandom_range(0, 7))};
    if ($urandom_range(0, 3) == 0) begin
      write_register(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                     CFG_DATA_W'($urandom));
    end
    write_register(REG_DIGIT_COUNT, count_data);
    write_register(REG_RADIX_0, pick_radix());
    write_register(REG_RADIX_1, pick_radix());
    write_register(REG_RADIX_2, pick_radix());
    write_register(REG_RADIX_3, pick_radix());
  endtask

  initial begin
    int unsigned       sent;
    int unsigned       phase;
    int unsigned       batch;
    logic [NUM_W-1:0]  num;
    plan = '{
      digits_row(32'd0, 3'd4, '{8'd0, 8'd0, 8'd0, 8'd0}),
      digits_row(32'd15, 3'd4, '{8'd1, 8'd1, 8'd1, 8'd1}),
      oversize_row(32'd16),
      oversize_row(32'hFFFF_FFFF),
      number_row(32'd5),
      write_row(REG_RADIX_0, 9'd256),
      write_row(REG_RADIX_1, 9'd256),
      write_row(REG_RADIX_2, 9'd256),
      write_row(REG_RADIX_3, 9'd256),
      digits_row(32'hFFFF_FFFF, 3'd4, '{8'hFF, 8'hFF, 8'hFF, 8'hFF}),
      digits_row(32'd0, 3'd4, '{8'd0, 8'd0, 8'd0, 8'd0}),
      digits_row(32'h1234_5678, 3'd4, '{8'h12, 8'h34, 8'h56, 8'h78}),
      // radices above the digit range saturate
      write_row(REG_RADIX_0, 9'd511),
      write_row(REG_RADIX_2, 9'd257),
      digits_row(32'hA5A5_A5A5, 3'd4, '{8'hA5, 8'hA5, 8'hA5, 8'hA5}),
      // zero count means one position, zero radix means radix one
      write_row(REG_DIGIT_COUNT, 9'd0),
      write_row(REG_RADIX_0, 9'd0),
      digits_row(32'd0, 3'd1, '{8'd0, 8'd0, 8'd0, 8'd0}),
      oversize_row(32'd1),
      write_row(REG_DIGIT_COUNT, 9'h1FF),
      write_row(REG_RADIX_0, 9'd1),
      write_row(REG_RADIX_1, 9'd0),
      write_row(REG_RADIX_2, 9'd3),
      write_row(REG_RADIX_3, 9'd256),
      number_row(32'd767),
      oversize_row(32'd768),
      number_row(32'd1000),
      write_row(REG_SPARE_FIRST, 9'd0),
      write_row(REG_SPARE_LAST, 9'h1FF),
      write_row(REG_DIGIT_COUNT, 9'h0FA),
      write_row(REG_RADIX_0, 9'd10),
      write_row(REG_RADIX_1, 9'd7),
      number_row(32'd69),
      oversize_row(32'd70),
      digits_row(32'd0, 3'd2, '{8'd0, 8'd0, 8'd0, 8'd0}),
      number_row(32'd23),
      write_row(REG_DIGIT_COUNT, 9'd3),
      write_row(REG_RADIX_0, 9'd257),
      write_row(REG_RADIX_1, 9'd255),
      write_row(REG_RADIX_2, 9'd1),
      number_row(32'd65279),
      oversize_row(32'd65280),
      number_row(32'd12345),
      write_row(REG_DIGIT_COUNT, 9'd5),
      write_row(REG_RADIX_0, 9'd256),
      write_row(REG_RADIX_1, 9'd256),
      write_row(REG_RADIX_2, 9'd256),
      write_row(REG_RADIX_3, 9'd255),
      number_row(32'hFEFF_FFFF),
      oversize_row(32'hFF00_0000)
    };

    repeat (2) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (plan[i].kind == ROW_WRITE) begin
        write_register(plan[i].index, plan[i].value[CFG_DATA_W-1:0]);
      end else begin
        feed_number(plan[i].value);
        if (plan[i].typed) begin
          queue_table_digits(plan[i]);
        end else begin
          predict_digits(plan[i].value);
        end
      end
    end

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      program_phase();
      steady = ($urandom_range(0, 4) == 0);
      if (phase == HOLD_PHASE) begin
        steady       = 1'b0;
        hold_out_req = 1'b1;
      end
      batch = $urandom_range(6, 24);
      repeat (batch) begin
        num = pick_number();
        feed_number(num);
        predict_digits(num);
        sent++;
      end
      phase++;
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // output side: random stalls, one long hold-off when asked
  initial begin
    int unsigned stall;
    do begin
      @(posedge clk);
    end while (!rst_ni);
    forever begin
      if (hold_out_req) begin
        hold_out_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = steady ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do begin
        @(posedge clk);
      end while (!m_axis_tvalid);
    end
  end

  always @(posedge clk) begin
    digit_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (digits_due.size() == 0) begin
        $error("digit item with none expected: tdata %h last %b too_large %b",
               m_axis_tdata, m_axis_tlast, m_axis_tuser);
        mismatches++;
      end else begin
        want = digits_due.pop_front();
        if (m_axis_tdata[DIGIT_W-1:0] !== want.digit) begin
          $error("digit: expected %0d, got %0d", want.digit, m_axis_tdata[DIGIT_W-1:0]);
          mismatches++;
        end
        if (m_axis_tdata[DIGIT_W +: POS_W] !== want.position) begin
          $error("position: expected %0d, got %0d", want.position,
                 m_axis_tdata[DIGIT_W +: POS_W]);
          mismatches++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
          mismatches++;
        end
        if (m_axis_tuser !== want.too_large) begin
          $error("too_large: expected %0b, got %0b", want.too_large, m_axis_tuser);
          mismatches++;
        end
      end
    end
  end

  // ends a run that has stopped moving
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

endmodule
